/* rtl/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the box versus frustum classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_W     = 64;
  localparam int NORM_W      = 16;
  localparam int TOL_W       = 16;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_W       = PLANE_W;

  localparam logic [REG_IDX_W-1:0] REG_TOL = 3'd6;

  typedef enum logic [1:0] {
    CLASS_INSIDE    = 2'd0,
    CLASS_INTERSECT = 2'd1,
    CLASS_OUTSIDE   = 2'd2
  } afc_class_e;

  // per-item status handed from cell to cell
  typedef struct packed {
    logic                   valid;
    logic [PLANE_COUNT-1:0] mask;
    logic                   all_in;
  } afc_flags_t;

endpackage

`default_nettype wire

/* rtl/afc_plane_cell.sv */
// ----------------------------------------------------------------------------
// afc_plane_cell
// One plane of the frustum: holds the plane register, forms the far and near
// corner distances over two stages and merges its verdict into the item.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_plane_cell #(
  parameter int COORD_BITS    = afc_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = afc_pkg::FRACTION_BITS_DEF,
  parameter int PLANE_IDX     = 0
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           plane_we_i,
  input  wire logic [afc_pkg::PLANE_W-1:0]    plane_data_i,
  input  wire logic [afc_pkg::TOL_W-1:0]      tol_i,
  input  wire afc_pkg::afc_flags_t            flags_i,
  input  wire logic [2:0][COORD_BITS-1:0]     lo_i,
  input  wire logic [2:0][COORD_BITS-1:0]     hi_i,
  output afc_pkg::afc_flags_t                 flags_o,
  output logic [2:0][COORD_BITS-1:0]          lo_o,
  output logic [2:0][COORD_BITS-1:0]          hi_o
);
  import afc_pkg::*;

  localparam int PW = NORM_W + COORD_BITS;
  localparam int OW = NORM_W + FRACTION_BITS;
  localparam int DW = ((PW > OW) ? PW : OW) + 2;

  logic [PLANE_W-1:0] plane_q;

  logic signed [PW-1:0] far_p_d  [3];
  logic signed [PW-1:0] near_p_d [3];
  logic signed [PW-1:0] far_p_q  [3];
  logic signed [PW-1:0] near_p_q [3];

  afc_flags_t                  flags_s1_q, flags_s2_d, flags_s2_q;
  logic [2:0][COORD_BITS-1:0]  lo_s1_q, hi_s1_q, lo_s2_q, hi_s2_q;

  logic signed [DW-1:0] off_scaled;
  logic signed [DW-1:0] neg_tol;
  logic signed [DW-1:0] far_sum;
  logic signed [DW-1:0] near_sum;

  // plane register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_data_i;
    end
  end

  // stage 1: corner select by normal sign, products
  always_comb begin
    logic signed [NORM_W-1:0] n;
    for (int a = 0; a < 3; a++) begin
      n = plane_q[a*NORM_W +: NORM_W];
      if (n[NORM_W-1]) begin
        far_p_d[a]  = n * $signed(lo_i[a]);
        near_p_d[a] = n * $signed(hi_i[a]);
      end else begin
        far_p_d[a]  = n * $signed(hi_i[a]);
        near_p_d[a] = n * $signed(lo_i[a]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_s1_q <= '0;
      flags_s2_q <= '0;
    end else begin
      flags_s1_q <= flags_i;
      flags_s2_q <= flags_s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    far_p_q           <= far_p_d;
    near_p_q          <= near_p_d;
    lo_s1_q           <= lo_i;
    hi_s1_q           <= hi_i;
    lo_s2_q           <= lo_s1_q;
    hi_s2_q           <= hi_s1_q;
  end

  // stage 2: sum with scaled offset, compare against minus tolerance
  always_comb begin
    off_scaled = DW'($signed(plane_q[3*NORM_W +: NORM_W])) <<< FRACTION_BITS;
    neg_tol    = '0 - DW'(tol_i);
    far_sum    = DW'(far_p_q[0]) + DW'(far_p_q[1]) + DW'(far_p_q[2]) + off_scaled;
    near_sum   = DW'(near_p_q[0]) + DW'(near_p_q[1]) + DW'(near_p_q[2]) + off_scaled;

    flags_s2_d = flags_s1_q;
    flags_s2_d.mask[PLANE_IDX] = (far_sum < neg_tol);
    flags_s2_d.all_in = flags_s1_q.all_in & ~(near_sum < neg_tol);
  end

  assign flags_o = flags_s2_q;
  assign lo_o    = lo_s2_q;
  assign hi_o    = hi_s2_q;

endmodule

`default_nettype wire

/* rtl/aabb_frustum_classifier.sv */
// ----------------------------------------------------------------------------
// aabb_frustum_classifier
// Classifies an axis-aligned box against six frustum planes with the
// positive/negative vertex test, one plane cell per plane in a chain.
// ----------------------------------------------------------------------------
// pipeline: start_i enters the first of the six plane cells in the chain; each
//   cell has a multiply stage and a sum stage, and the class register after
//   the last cell holds the result
// throughput: one item per cycle, busy_o stays low; valid_o is never stalled
// reset: planes clear to zero, tolerance to one, the chain empties
`default_nettype none

module aabb_frustum_classifier #(
  parameter int COORD_BITS    = afc_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = afc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [afc_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [afc_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic signed [COORD_BITS-1:0]    min_x_i,
  input  wire logic signed [COORD_BITS-1:0]    min_y_i,
  input  wire logic signed [COORD_BITS-1:0]    min_z_i,
  input  wire logic signed [COORD_BITS-1:0]    max_x_i,
  input  wire logic signed [COORD_BITS-1:0]    max_y_i,
  input  wire logic signed [COORD_BITS-1:0]    max_z_i,
  output logic                                 valid_o,
  output logic [1:0]                           box_class_o,
  output logic [afc_pkg::PLANE_COUNT-1:0]      reject_mask_o
);
  import afc_pkg::*;

  logic [TOL_W-1:0] tol_q;

  afc_flags_t                  flags [PLANE_COUNT+1];
  logic [2:0][COORD_BITS-1:0]  lo    [PLANE_COUNT+1];
  logic [2:0][COORD_BITS-1:0]  hi    [PLANE_COUNT+1];

  logic                   valid_q;
  afc_class_e             class_d, class_q;
  logic [PLANE_COUNT-1:0] mask_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_we_i && (cfg_idx_i == REG_TOL)) begin
      tol_q <= cfg_data_i[TOL_W-1:0];
    end
  end

  assign flags[0].valid  = start_i;
  assign flags[0].mask   = '0;
  assign flags[0].all_in = 1'b1;
  assign lo[0] = {min_z_i, min_y_i, min_x_i};
  assign hi[0] = {max_z_i, max_y_i, max_x_i};

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    afc_plane_cell #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .PLANE_IDX     (p)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .plane_we_i   (cfg_we_i && (cfg_idx_i == REG_IDX_W'(p))),
      .plane_data_i (cfg_data_i),
      .tol_i        (tol_q),
      .flags_i      (flags[p]),
      .lo_i         (lo[p]),
      .hi_i         (hi[p]),
      .flags_o      (flags[p+1]),
      .lo_o         (lo[p+1]),
      .hi_o         (hi[p+1])
    );
  end

  always_comb begin
    if (flags[PLANE_COUNT].mask != '0) begin
      class_d = CLASS_OUTSIDE;
    end else if (flags[PLANE_COUNT].all_in) begin
      class_d = CLASS_INSIDE;
    end else begin
      class_d = CLASS_INTERSECT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= flags[PLANE_COUNT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    class_q <= class_d;
    mask_q  <= flags[PLANE_COUNT].mask;
  end

  assign valid_o       = valid_q;
  assign box_class_o   = class_q;
  assign reject_mask_o = mask_q;

  a_valid_follows_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(flags[PLANE_COUNT].valid))
    else $error("result strobe does not follow the last cell");

  a_outside_has_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (reject_mask_o != '0)) |-> (box_class_o == CLASS_OUTSIDE))
    else $error("rejected item not classed outside");

  a_no_mask_not_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (reject_mask_o == '0)) |-> (box_class_o != CLASS_OUTSIDE))
    else $error("item classed outside with empty reject mask");

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the box versus frustum classifier. A scoreboard
// predicts class and reject mask for every accepted box from its own copy of
// the plane and tolerance registers. Boxes stream in under several register
// settings, with random idle gaps, and every strobed result is checked.
// ----------------------------------------------------------------------------
module tb;
  import afc_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;

  localparam logic [REG_IDX_W-1:0] REG_PLANE_LEFT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED     = 3'd7;

  typedef enum int {
    PLANES_AXIS,
    PLANES_NOISE,
    PLANES_EXTREME
  } plane_kind_e;

  typedef struct {
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
  } box_t;

  typedef struct {
    afc_class_e             cls;
    logic [PLANE_COUNT-1:0] mask;
  } verdict_t;

  class frustum_scoreboard;
    logic [PLANE_W-1:0] planes [PLANE_COUNT];
    logic [TOL_W-1:0]   tol;
    verdict_t           verdict_q[$];
    int unsigned        fails;
    int unsigned        boxes;
    int unsigned        class_hits [3];

    function new();
      foreach (planes[p]) planes[p] = '0;
      tol = 1;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx < PLANE_COUNT) planes[idx] = data;
      else if (idx == REG_TOL) tol = data[TOL_W-1:0];
    endfunction

    // positive/negative vertex test, exact in 64-bit
    function void note_box(box_t b);
      longint   far_d, near_d, n, neg_tol;
      bit       all_in;
      verdict_t v;
      neg_tol = -longint'(tol);
      all_in = 1'b1;
      v.mask = '0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        far_d = longint'($signed(planes[p][63:48])) * (longint'(1) << FRAC);
        near_d = far_d;
        for (int a = 0; a < 3; a++) begin
          n = longint'($signed(planes[p][16*a +: 16]));
          // zero component counts as non-negative
          if (n >= 0) begin
            far_d += n * longint'(b.hi[a]);
            near_d += n * longint'(b.lo[a]);
          end else begin
            far_d += n * longint'(b.lo[a]);
            near_d += n * longint'(b.hi[a]);
          end
        end
        if (far_d < neg_tol) v.mask[p] = 1'b1;
        if (near_d < neg_tol) all_in = 1'b0;
      end
      if (v.mask != '0) v.cls = CLASS_OUTSIDE;
      else if (all_in) v.cls = CLASS_INSIDE;
      else v.cls = CLASS_INTERSECT;
      verdict_q = {verdict_q, v};
      boxes++;
    endfunction

    function void check_result(logic [1:0] cls, logic [PLANE_COUNT-1:0] mask);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("result with no box pending: class %0d mask %b", cls, mask);
        fails++;
        return;
      end
      v = verdict_q.pop_front();
      class_hits[v.cls]++;
      if (cls !== v.cls) begin
        $error("box_class: expected %0d, got %0d", v.cls, cls);
        fails++;
      end
      if (mask !== v.mask) begin
        $error("reject_mask: expected %b, got %b", v.mask, mask);
        fails++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [REG_IDX_W-1:0]         cfg_idx_i;
  logic [CFG_W-1:0]             cfg_data_i;
  logic                         start_i;
  logic                         busy_o;
  logic signed [15:0]           min_x_i, min_y_i, min_z_i;
  logic signed [15:0]           max_x_i, max_y_i, max_z_i;
  logic                         valid_o;
  logic [1:0]                   box_class_o;
  logic [PLANE_COUNT-1:0]       reject_mask_o;

  frustum_scoreboard sb = new();
  int unsigned       settings;

  aabb_frustum_classifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .min_x_i      (min_x_i),
    .min_y_i      (min_y_i),
    .min_z_i      (min_z_i),
    .max_x_i      (max_x_i),
    .max_y_i      (max_y_i),
    .max_z_i      (max_z_i),
    .valid_o      (valid_o),
    .box_class_o  (box_class_o),
    .reject_mask_o(reject_mask_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) sb.check_result(box_class_o, reject_mask_o);
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int off);
    return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo[0] = 16'(lx); b.lo[1] = 16'(ly); b.lo[2] = 16'(lz);
    b.hi[0] = 16'(hx); b.hi[1] = 16'(hy); b.hi[2] = 16'(hz);
    return b;
  endfunction

  function automatic box_t random_box();
    box_t               b;
    int                 c, h;
    logic signed [15:0] t;
    bit                 noise;
    noise = ($urandom_range(99) < 15);
    for (int a = 0; a < 3; a++) begin
      if (noise) begin
        b.lo[a] = 16'($urandom);
        b.hi[a] = 16'($urandom);
      end else begin
        c = int'($urandom_range(24000)) - 12000;
        h = $urandom_range(3000);
        b.lo[a] = 16'(c - h);
        b.hi[a] = 16'(c + h);
      end
    end
    // occasionally an inverted box, used as given
    if ($urandom_range(99) < 10) begin
      t = b.lo[0]; b.lo[0] = b.hi[0]; b.hi[0] = t;
    end
    return b;
  endfunction

  function automatic logic [15:0] extreme_half();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [63:0] random_plane(plane_kind_e kind, int p);
    int n [3];
    int side;
    case (kind)
      PLANES_NOISE: return {$urandom, $urandom};
      PLANES_EXTREME: return {extreme_half(), extreme_half(), extreme_half(), extreme_half()};
      default: begin
        // one dominant axis per plane pair, small tilt or zero elsewhere
        side = (p % 2) ? -1 : 1;
        for (int a = 0; a < 3; a++) begin
          if (a == p / 2) n[a] = side * int'($urandom_range(128, 512));
          else if ($urandom_range(2) == 0) n[a] = 0;
          else n[a] = int'($urandom_range(64)) - 32;
        end
        return pack_plane(n[0], n[1], n[2], $urandom_range(256, 8192));
      end
    endcase
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_planes(logic [63:0] pl [PLANE_COUNT], logic [TOL_W-1:0] tol_val);
    for (int p = 0; p < PLANE_COUNT; p++) write_reg(REG_IDX_W'(REG_PLANE_LEFT + p), pl[p]);
    write_reg(REG_TOL, CFG_W'(tol_val));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic send_box(box_t b);
    start_i <= 1'b1;
    min_x_i <= b.lo[0]; min_y_i <= b.lo[1]; min_z_i <= b.lo[2];
    max_x_i <= b.hi[0]; max_y_i <= b.hi[1]; max_z_i <= b.hi[2];
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_box(b);
  endtask

  task automatic pause(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // drain the pipeline before touching registers
  task automatic drain();
    start_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic stream_boxes(int unsigned count, bit quiet);
    for (int unsigned i = 0; i < count; i++) begin
      send_box(random_box());
      if (!quiet && $urandom_range(99) < 25) pause($urandom_range(1, 3));
    end
    drain();
  endtask

  initial begin
    logic [63:0]      pl [PLANE_COUNT];
    logic [TOL_W-1:0] tol_val;
    plane_kind_e      kind;

    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    start_i    <= 1'b0;
    min_x_i    <= '0; min_y_i <= '0; min_z_i <= '0;
    max_x_i    <= '0; max_y_i <= '0; max_z_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset planes are all zero: everything lands inside
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(100, 100, 100, -100, -100, -100));
    drain();

    // unused index must be ignored
    write_reg(REG_UNUSED, 64'hdead_beef_cafe_f00d);

    // axis-aligned cube of half width 4096 in box coordinates, zero tolerance
    pl[0] = pack_plane(256, 0, 0, 4096);
    pl[1] = pack_plane(-256, 0, 0, 4096);
    pl[2] = pack_plane(0, 256, 0, 4096);
    pl[3] = pack_plane(0, -256, 0, 4096);
    pl[4] = pack_plane(0, 0, 256, 4096);
    pl[5] = pack_plane(0, 0, -256, 4096);
    program_planes(pl, 16'd0);
    send_box(make_box(-100, -100, -100, 100, 100, 100));
    send_box(make_box(5000, -100, -100, 6000, 100, 100));
    send_box(make_box(-5000, -100, -100, 0, 100, 100));
    send_box(make_box(-4096, -4096, -4096, 4096, 4096, 4096));
    send_box(make_box(-4097, 0, 0, -4097, 0, 0));
    send_box(make_box(100, 100, 100, -100, -100, -100));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    drain();

    // largest magnitudes everywhere, widest tolerance
    for (int p = 0; p < PLANE_COUNT; p++) pl[p] = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    pl[5] = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    program_planes(pl, 16'hffff);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4 || ph == 7) kind = PLANES_NOISE;
      else if (ph == 2 || ph == 8) kind = PLANES_EXTREME;
      else kind = PLANES_AXIS;
      case (ph)
        0: tol_val = 16'd0;
        1: tol_val = 16'hffff;
        5: tol_val = 16'd1;
        default: tol_val = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(64));
      endcase
      for (int p = 0; p < PLANE_COUNT; p++) pl[p] = random_plane(kind, p);
      program_planes(pl, tol_val);
      // one setting runs back to back with no gaps
      stream_boxes(150, ph == 3);
    end

    drain();
    $display("%0d boxes classified under %0d register settings",
             sb.boxes, settings);
    $display("inside %0d, intersecting %0d, outside %0d",
             sb.class_hits[CLASS_INSIDE], sb.class_hits[CLASS_INTERSECT],
             sb.class_hits[CLASS_OUTSIDE]);
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
